// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; a clk and rst must be in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mpow_pkg.sv -----
// ----------------------------------------------------------------------------
// mpow_pkg
// Sizes, command and status types shared by the matrix power block.
// ----------------------------------------------------------------------------
package mpow_pkg;

  localparam int MAX_SIZE = 8;
  localparam int CELLS    = MAX_SIZE * MAX_SIZE;
  localparam int AW       = $clog2(CELLS);
  localparam int IW       = $clog2(MAX_SIZE);
  localparam int NW       = $clog2(MAX_SIZE + 1);
  localparam int CW       = $clog2(CELLS + 1);
  localparam int DW       = 32;
  localparam int EXP_W    = 16;
  localparam int BIT_W    = $clog2(EXP_W);
  localparam int SIZE_W   = 4;
  localparam int ROW_W    = 3;

  typedef struct packed {
    logic          base_we;
    logic [AW-1:0] base_addr;
    logic          init_we;
    logic [AW-1:0] init_addr;
    logic          init_one;
    logic          mac_vld;
    logic          mac_first;
    logic          mac_last;
    logic          use_base;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;
    logic [AW-1:0] c_addr;
    logic          cp_vld;
    logic [AW-1:0] cp_addr;
    logic          out_rd;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] c);
    cell_addr = AW'(AW'(r) * AW'(MAX_SIZE) + AW'(c));
  endfunction

endpackage

// ----- hw/rtl/matrix_power_by_squaring_core.sv -----
// ----------------------------------------------------------------------------
// matrix_power_by_squaring_core
// Loads an n-by-n matrix, raises it to a power and streams out the result.
// ----------------------------------------------------------------------------
// Usage: set matrix_size (byte address 0) and exponent (byte address 4) over
// the APB port while the block is idle. Then send n*n input transactions on
// in_valid/in_stall, one element_value each, in row-major order; each is taken
// in the cycle that offers it. On the last element the block stalls its input
// and computes. It scans the 16 exponent bits from the top, squaring an
// accumulator that starts as the identity and multiplying it by the loaded
// matrix at set bits. A product runs on one multiply-accumulate unit at one
// term per cycle, and is then copied back from the scratch store. The result
// leaves as n*n output transactions in row-major order, each read from the
// store before it is offered, with row_index, col_index, result_value and
// last_element on the final one. Arithmetic wraps modulo 2^32. When the
// receiver stalls, the current transaction holds and the block waits. After
// last_element is taken the block accepts a new matrix. Reset restores
// matrix_size 3, exponent 1 and an empty load; the matrix stores hold no
// reset value and need no clearing.
`include "assert_macros.svh"

module matrix_power_by_squaring_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mpow_pkg::DW-1:0]    element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mpow_pkg::ROW_W-1:0]        row_index,
  output logic [mpow_pkg::ROW_W-1:0]        col_index,
  output logic signed [mpow_pkg::DW-1:0]    result_value,
  output logic                              last_element
);

  logic [mpow_pkg::SIZE_W-1:0] matrix_size;
  logic [mpow_pkg::EXP_W-1:0]  exponent;
  logic [mpow_pkg::NW-1:0]     n;
  logic [mpow_pkg::DW-1:0]     rd_value;
  mpow_pkg::cmd_t              cmd;
  mpow_pkg::sts_t              sts;

  // Configuration registers; bit 2 of the address selects the register.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= mpow_pkg::SIZE_W'(3);
      exponent    <= mpow_pkg::EXP_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) exponent    <= pwdata[mpow_pkg::EXP_W-1:0];
      else          matrix_size <= pwdata[mpow_pkg::SIZE_W-1:0];
    end
  end
  assign prdata = paddr[2] ? 32'(exponent) : 32'(matrix_size);

  // A size of zero counts as one, and a size beyond the stores is clamped.
  always_comb begin
    if (matrix_size == '0) begin
      n = mpow_pkg::NW'(1);
    end else if (32'(matrix_size) > mpow_pkg::MAX_SIZE) begin
      n = mpow_pkg::NW'(mpow_pkg::MAX_SIZE);
    end else begin
      n = mpow_pkg::NW'(matrix_size);
    end
  end

  mpow_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .n            (n),
    .exponent     (exponent),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .row_index    (row_index),
    .col_index    (col_index),
    .last_element (last_element),
    .cmd          (cmd),
    .sts          (sts)
  );

  mpow_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .element_value (element_value),
    .sts           (sts),
    .rd_value      (rd_value)
  );

  assign result_value = rd_value;

  // No element is loaded while a result is on offer.
  `ASSERT_IMPL(a_no_load_in_output, out_valid, in_stall, "input taken during output")
  // The final result element ends the output phase.
  `ASSERT_NEXT(a_last_ends, out_valid && !out_stall && last_element, !out_valid,
               "output continued after last element")
  // Each accepted result is followed by a read state before the next is offered.
  `ASSERT_NEXT(a_out_gap, out_valid && !out_stall, !out_valid, "back-to-back result")

endmodule

// ----- hw/rtl/mpow_dp.sv -----
// ----------------------------------------------------------------------------
// mpow_dp
// Matrix stores and the pipelined multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module mpow_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  mpow_pkg::cmd_t             cmd,
  input  logic [mpow_pkg::DW-1:0]    element_value,
  output mpow_pkg::sts_t             sts,
  output logic [mpow_pkg::DW-1:0]    rd_value
);

  logic [mpow_pkg::DW-1:0] base_mem [mpow_pkg::CELLS];
  logic [mpow_pkg::DW-1:0] work_mem [mpow_pkg::CELLS];
  logic [mpow_pkg::DW-1:0] scr_mem  [mpow_pkg::CELLS];

  logic [mpow_pkg::DW-1:0] wa_q, wb_q, bs_q, sc_q, prod, acc;
  logic [mpow_pkg::DW-1:0] prod_full;
  logic [mpow_pkg::DW-1:0] rhs, sum;
  logic s1_vld, s1_first, s1_last, s1_base;
  logic s2_vld, s2_first, s2_last;
  logic [mpow_pkg::AW-1:0] s1_addr, s2_addr, cp1_addr;
  logic cp1_vld;

  // Stage 1: registered memory reads.
  always_ff @(posedge clk) begin
    if (cmd.base_we) base_mem[cmd.base_addr] <= element_value;
    if (cmd.mac_vld || cmd.out_rd) wa_q <= work_mem[cmd.a_addr];
    if (cmd.mac_vld) begin
      wb_q <= work_mem[cmd.b_addr];
      bs_q <= base_mem[cmd.b_addr];
    end
    if (cmd.cp_vld) sc_q <= scr_mem[cmd.cp_addr];
    s1_first <= cmd.mac_first;
    s1_last  <= cmd.mac_last;
    s1_base  <= cmd.use_base;
    s1_addr  <= cmd.c_addr;
    cp1_addr <= cmd.cp_addr;
  end

  // Only the low word of each product is kept, as arithmetic wraps.
  assign rhs       = s1_base ? bs_q : wb_q;
  assign prod_full = wa_q * rhs;
  assign sum       = s2_first ? prod : acc + prod;

  // Stage 2: product; stage 3: accumulate and write back.
  always_ff @(posedge clk) begin
    prod     <= prod_full;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_addr  <= s1_addr;
    if (s2_vld) begin
      acc <= sum;
      if (s2_last) scr_mem[s2_addr] <= sum;
    end
    if (cmd.init_we) begin
      work_mem[cmd.init_addr] <= cmd.init_one ? mpow_pkg::DW'(1) : '0;
    end else if (cp1_vld) begin
      work_mem[cp1_addr] <= sc_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      cp1_vld <= 1'b0;
    end else begin
      s1_vld  <= cmd.mac_vld;
      s2_vld  <= s1_vld;
      cp1_vld <= cmd.cp_vld;
    end
  end

  assign sts.busy = s1_vld | s2_vld | cp1_vld;
  assign rd_value = wa_q;

endmodule

// ----- hw/rtl/mpow_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpow_ctrl
// Sequencer for loading, squaring, multiplying, copying and unloading.
// ----------------------------------------------------------------------------
module mpow_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mpow_pkg::NW-1:0]       n,
  input  logic [mpow_pkg::EXP_W-1:0]    exponent,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mpow_pkg::ROW_W-1:0]    row_index,
  output logic [mpow_pkg::ROW_W-1:0]    col_index,
  output logic                          last_element,
  output mpow_pkg::cmd_t                cmd,
  input  mpow_pkg::sts_t                sts
);

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_DRAIN  = 4'd3;
  localparam logic [3:0] S_COPY   = 4'd4;
  localparam logic [3:0] S_CDRAIN = 4'd5;
  localparam logic [3:0] S_OUTRD  = 4'd6;
  localparam logic [3:0] S_OUTV   = 4'd7;

  logic [3:0] state;
  logic [mpow_pkg::IW-1:0] ri, ci, ki, lrow, lcol, nm1;
  logic [mpow_pkg::CW-1:0] load_count, lc_eff, lc_next, total;
  logic [mpow_pkg::BIT_W-1:0] bit_idx;
  logic use_base, in_acc, i_end, j_end, k_end;

  assign nm1   = mpow_pkg::IW'(n - mpow_pkg::NW'(1));
  assign total = mpow_pkg::CW'(n) * mpow_pkg::CW'(n);
  assign i_end = (ri == nm1);
  assign j_end = (ci == nm1);
  assign k_end = (ki == nm1);

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid & ~in_stall;

  assign lc_eff  = (load_count >= total) ? '0 : load_count;
  assign lc_next = lc_eff + mpow_pkg::CW'(1);

  // Row of the incoming element: count the row boundaries already passed.
  always_comb begin
    lrow = '0;
    for (int r = 1; r < mpow_pkg::MAX_SIZE; r++) begin
      if (lc_eff >= mpow_pkg::CW'(r) * mpow_pkg::CW'(n)) lrow = mpow_pkg::IW'(r);
    end
    lcol = mpow_pkg::IW'(lc_eff - mpow_pkg::CW'(lrow) * mpow_pkg::CW'(n));
  end

  always_comb begin
    cmd           = '0;
    cmd.base_we   = in_acc;
    cmd.base_addr = mpow_pkg::cell_addr(lrow, lcol);
    cmd.init_we   = (state == S_INIT);
    cmd.init_addr = mpow_pkg::cell_addr(ri, ci);
    cmd.init_one  = (ri == ci);
    cmd.mac_vld   = (state == S_MUL);
    cmd.mac_first = (ki == '0);
    cmd.mac_last  = k_end;
    cmd.use_base  = use_base;
    cmd.a_addr    = (state == S_OUTRD) ? mpow_pkg::cell_addr(ri, ci)
                                       : mpow_pkg::cell_addr(ri, ki);
    cmd.b_addr    = mpow_pkg::cell_addr(ki, ci);
    cmd.c_addr    = mpow_pkg::cell_addr(ri, ci);
    cmd.cp_vld    = (state == S_COPY);
    cmd.cp_addr   = mpow_pkg::cell_addr(ri, ci);
    cmd.out_rd    = (state == S_OUTRD);
  end

  assign out_valid    = (state == S_OUTV);
  assign row_index    = mpow_pkg::ROW_W'(ri);
  assign col_index    = mpow_pkg::ROW_W'(ci);
  assign last_element = i_end & j_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      ri         <= '0;
      ci         <= '0;
      ki         <= '0;
      bit_idx    <= '0;
      use_base   <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (lc_next == total) begin
              load_count <= '0;
              ri         <= '0;
              ci         <= '0;
              state      <= S_INIT;
            end else begin
              load_count <= lc_next;
            end
          end
        end
        S_INIT, S_COPY, S_OUTV: begin
          if (state != S_OUTV || !out_stall) begin
            if (j_end) begin
              ci <= '0;
              if (i_end) begin
                ri <= '0;
                case (state)
                  S_INIT: begin
                    bit_idx  <= mpow_pkg::BIT_W'(mpow_pkg::EXP_W - 1);
                    use_base <= 1'b0;
                    ki       <= '0;
                    state    <= S_MUL;
                  end
                  S_COPY:  state <= S_CDRAIN;
                  default: state <= S_LOAD;
                endcase
              end else begin
                ri <= ri + 1'b1;
                if (state == S_OUTV) state <= S_OUTRD;
              end
            end else begin
              ci <= ci + 1'b1;
              if (state == S_OUTV) state <= S_OUTRD;
            end
          end
        end
        S_MUL: begin
          if (k_end) begin
            ki <= '0;
            if (j_end) begin
              ci <= '0;
              if (i_end) begin
                ri    <= '0;
                state <= S_DRAIN;
              end else begin
                ri <= ri + 1'b1;
              end
            end else begin
              ci <= ci + 1'b1;
            end
          end else begin
            ki <= ki + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!sts.busy) state <= S_COPY;
        end
        S_CDRAIN: begin
          if (!sts.busy) begin
            if (!use_base && exponent[bit_idx]) begin
              use_base <= 1'b1;
              state    <= S_MUL;
            end else if (bit_idx == '0) begin
              state <= S_OUTRD;
            end else begin
              bit_idx  <= bit_idx - 1'b1;
              use_base <= 1'b0;
              state    <= S_MUL;
            end
          end
        end
        S_OUTRD: state <= S_OUTV;
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ----- sim/matrix_power_by_squaring_core_test.sv -----
// ----------------------------------------------------------------------------
// matrix_power_by_squaring_core_test
// Self-checking bench: loads matrices, predicts every power result element by
// square-and-multiply in the bench, and compares each output transaction.
// ----------------------------------------------------------------------------
module matrix_power_by_squaring_core_test;

  // Register byte addresses on the APB port.
  localparam logic [2:0] ADDR_MATRIX_SIZE = 3'd0;
  localparam logic [2:0] ADDR_EXPONENT    = 3'd4;
  localparam int         CYCLE_LIMIT      = 2000000;
  localparam int         RANDOM_ITEMS     = 95;

  typedef struct {
    logic [mpow_pkg::ROW_W-1:0] row;
    logic [mpow_pkg::ROW_W-1:0] col;
    logic [mpow_pkg::DW-1:0]    value;
    logic                       last;
  } element_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  logic signed [mpow_pkg::DW-1:0] element_value;
  logic out_valid;
  logic out_stall;
  logic [mpow_pkg::ROW_W-1:0] row_index;
  logic [mpow_pkg::ROW_W-1:0] col_index;
  logic signed [mpow_pkg::DW-1:0] result_value;
  logic last_element;

  // Bench copy of the block's state and registers.
  logic [mpow_pkg::SIZE_W-1:0] size_reg;
  logic [mpow_pkg::EXP_W-1:0]  exp_reg;
  logic [mpow_pkg::DW-1:0]     loaded_matrix [mpow_pkg::CELLS];
  int                          elements_loaded;
  element_result_t             pending_elements [$];

  int  mismatch_count;
  int  cycle_count;
  int  stall_left;
  bit  quiet_phase;

  matrix_power_by_squaring_core uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A watchdog that ends a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  function automatic int used_size();
    if (size_reg == 0) return 1;
    if (size_reg > mpow_pkg::MAX_SIZE) return mpow_pkg::MAX_SIZE;
    return int'(size_reg);
  endfunction

  // Raises the loaded matrix to exp_reg and queues the n*n result elements.
  function automatic void predict_power(input int n);
    logic [mpow_pkg::DW-1:0] acc [mpow_pkg::CELLS];
    logic [mpow_pkg::DW-1:0] prod [mpow_pkg::CELLS];
    logic [mpow_pkg::DW-1:0] sum;
    element_result_t r;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        acc[i*mpow_pkg::MAX_SIZE+j] = (i == j) ? 32'd1 : 32'd0;
    for (int b = mpow_pkg::EXP_W - 1; b >= 0; b--) begin
      for (int pass = 0; pass < 2; pass++) begin
        if (pass == 1 && !exp_reg[b]) continue;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            sum = '0;
            for (int k = 0; k < n; k++)
              sum += acc[i*mpow_pkg::MAX_SIZE+k] *
                     ((pass == 0) ? acc[k*mpow_pkg::MAX_SIZE+j]
                                  : loaded_matrix[k*mpow_pkg::MAX_SIZE+j]);
            prod[i*mpow_pkg::MAX_SIZE+j] = sum;
          end
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            acc[i*mpow_pkg::MAX_SIZE+j] = prod[i*mpow_pkg::MAX_SIZE+j];
      end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        r.row   = mpow_pkg::ROW_W'(i);
        r.col   = mpow_pkg::ROW_W'(j);
        r.value = acc[i*mpow_pkg::MAX_SIZE+j];
        r.last  = (i == n - 1 && j == n - 1);
        pending_elements.push_back(r);
      end
  endfunction

  // Places one accepted element and predicts results when the matrix is full.
  function automatic void record_element(input logic [mpow_pkg::DW-1:0] v);
    int n;
    n = used_size();
    if (elements_loaded >= n * n) elements_loaded = 0;
    loaded_matrix[(elements_loaded / n) * mpow_pkg::MAX_SIZE + elements_loaded % n] = v;
    elements_loaded++;
    if (elements_loaded == n * n) begin
      elements_loaded = 0;
      predict_power(n);
    end
  endfunction

  // Sends one input transaction, at random with an idle burst ahead of it unless
  // the run is in its quiet tail. The stall is sampled at the falling edge, so
  // the next rising edge is the one that takes the transaction.
  task automatic send_element(input logic [mpow_pkg::DW-1:0] v);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    element_value <= v;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    record_element(v);
  endtask

  // Waits until every predicted element has come out and the block is idle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_elements.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MATRIX_SIZE) size_reg = data[mpow_pkg::SIZE_W-1:0];
    else exp_reg = data[mpow_pkg::EXP_W-1:0];
  endtask

  task automatic configure(input int size, input int power);
    wait_drained();
    write_register(ADDR_MATRIX_SIZE, 32'(size));
    write_register(ADDR_EXPONENT, 32'(power));
  endtask

  // Reset values: a 3-by-3 matrix to the first power, with extreme elements.
  task automatic test_reset_defaults();
    logic [mpow_pkg::DW-1:0] extremes [9] = '{32'h8000_0000, 32'h7fff_ffff,
                                              32'hffff_ffff, 32'h0, 32'h1,
                                              32'haaaa_aaaa, 32'h5555_5555,
                                              32'h8000_0001, 32'h7fff_fffe};
    foreach (extremes[i]) send_element(extremes[i]);
  endtask

  // Exponent zero must yield the identity whatever was loaded.
  task automatic test_exponent_zero();
    configure(2, 0);
    repeat (4) send_element($urandom);
  endtask

  // A size of zero behaves as one; the largest exponent and a 2-by-2 cube wrap.
  task automatic test_size_clamp();
    configure(0, 65535);
    send_element(32'h7fff_ffff);
    send_element(32'hffff_ffff);
    configure(2, 3);
    send_element(32'hffff_ffff);
    send_element(32'h8000_0000);
    send_element(32'h7fff_ffff);
    send_element(32'h1);
  endtask

  // Random matrices: mostly small sizes, a few at or above the largest size.
  task automatic test_random_powers();
    int sent;
    int size;
    int power;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       size = $urandom_range(8, 15);
        1:       size = 0;
        default: size = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 5))
        0:       power = 0;
        1:       power = 65535;
        2:       power = $urandom_range(0, 65535);
        default: power = $urandom_range(1, 12);
      endcase
      configure(size, power);
      quiet_phase = (sent > RANDOM_ITEMS * 3 / 4);
      for (int i = 0; i < used_size() * used_size(); i++) begin
        if ($urandom_range(0, 1)) send_element($urandom);
        else send_element(32'($signed($urandom_range(0, 6)) - 3));
        sent++;
      end
    end
  endtask

  // Receiver side: stalls come in random bursts, and stop in the quiet tail.
  always @(posedge clk) begin
    if (rst || quiet_phase) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 18);
    end
  end

  // Each accepted output transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    element_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_elements.size() == 0) begin
        report_mismatch("unexpected element", {26'd0, row_index, col_index}, 32'd0);
      end else begin
        want = pending_elements.pop_front();
        if (row_index !== want.row) report_mismatch("row_index", row_index, want.row);
        if (col_index !== want.col) report_mismatch("col_index", col_index, want.col);
        if (result_value !== want.value)
          report_mismatch("result_value", result_value, want.value);
        if (last_element !== want.last)
          report_mismatch("last_element", last_element, want.last);
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    element_value = '0;
    out_stall = 1'b0;
    stall_left = 0;
    size_reg = 4'd3;
    exp_reg = 16'd1;
    elements_loaded = 0;
    mismatch_count = 0;
    cycle_count = 0;
    quiet_phase = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_exponent_zero();
    test_size_clamp();
    test_random_powers();

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
